// ===== design/smf_pkg.sv =====
// Shared types and constants for the sliding-window mode filter.
// No dependencies; compile first.
`default_nettype none

package smf_pkg;

    // Field widths of the channels and configuration port
    localparam int KIND_W   = 1;
    localparam int SAMPLE_W = 16;
    localparam int MCOUNT_W = 5;
    localparam int WCOUNT_W = 5;
    localparam int TMO_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_TICK   = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;

    // Register reset values
    localparam logic [WCOUNT_W-1:0] WINDOW_COUNT_RST  = 5'd5;
    localparam logic [TMO_W-1:0]    TIMEOUT_TICKS_RST = 8'd10;

    // Per-cycle command broadcast to every window cell
    typedef struct packed {
        logic push;    // shift a new sample into the window
        logic clear;   // empty the window
        logic load;    // copy value into probe, zero match count
        logic count;   // compare probe with value, rotate probe
        logic reload;  // copy value into probe, keep match count
        logic drain;   // shift probe and count toward the last cell
    } smf_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/smf_if.sv =====
// Valid/ready channel interfaces for sample beats and result beats.
// Depends on smf_pkg.
`default_nettype none

interface smf_in_if;
    import smf_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output kind, output sample_value, input ready);
    modport sink   (input valid, input kind, input sample_value, output ready);
endinterface

interface smf_out_if;
    import smf_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] mode_value;
    logic [MCOUNT_W-1:0] mode_count;

    modport source (output valid, output mode_value, output mode_count, input ready);
    modport sink   (input valid, input mode_value, input mode_count, output ready);
endinterface

`default_nettype wire

// ===== design/sliding_window_mode_filter.sv =====
// Top level of the sliding-window mode filter: window cell chain, sequencer,
// idle timer and result register. Depends on smf_pkg, smf_if, smf_cell.
//
//  channel    dir  beat contents               handshake
//  sample_ch  in   kind, sample_value          valid/ready
//  result_ch  out  mode_value, mode_count      valid/ready
//  cfg        in   cfg_index, cfg_data         cfg_we, no stall
//
// A tick is handled in IDLE. A sample is shifted in, then LOAD copies values
// into the probes, COUNT rotates probes around the cell ring and counts matches,
// RELOAD copies values into the probes again, DRAIN shifts counts out of the last
// cell past the best-value tracker, and DONE writes the result.
// Reset empties the window and loads the register defaults.
// A result waiting on result_ch does not stop new beats from being taken;
// the next result waits in DONE until the result register frees up.
`default_nettype none

module sliding_window_mode_filter #(
    parameter int WINDOW_MAX = 16,
    parameter int VALUE_BITS = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    smf_in_if.sink                            sample_ch,
    smf_out_if.source                         result_ch,
    input  wire                               cfg_we,
    input  wire  [smf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [smf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import smf_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COUNT,
        ST_RELOAD,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                state_reg;
    logic [WCOUNT_W-1:0]   wcount_reg;
    logic [TMO_W-1:0]      timeout_reg;
    logic [TMO_W-1:0]      idle_reg;
    logic [TMO_W-1:0]      idle_next;
    logic [IDX_W-1:0]      step_reg;
    logic [VALUE_BITS-1:0] best_val_reg;
    logic [CNT_W-1:0]      best_cnt_reg;
    logic                  ov_reg;
    logic [SAMPLE_W-1:0]   out_val_reg;
    logic [MCOUNT_W-1:0]   out_cnt_reg;

    logic                  in_acc;
    logic                  is_tick;
    logic                  step_last;
    logic                  better;
    logic                  out_free;
    logic [CNT_W-1:0]      len;
    smf_cell_ctrl_t        ctrl;

    logic [VALUE_BITS-1:0] val_w  [WINDOW_MAX];
    logic [VALUE_BITS-1:0] prb_w  [WINDOW_MAX];
    logic [CNT_W-1:0]      cnt_w  [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] vld_w;
    logic [WINDOW_MAX-1:0] pvld_w;
    logic [WINDOW_MAX-1:0] keep_w;

    // Handshake
    assign sample_ch.ready = (state_reg == ST_IDLE);
    assign in_acc          = sample_ch.valid && sample_ch.ready;
    assign is_tick         = (sample_ch.kind == KIND_TICK);
    assign out_free        = !ov_reg || result_ch.ready;

    // Effective window length: zero acts as one, clamp at WINDOW_MAX
    always_comb
    begin
        if (wcount_reg == '0)
            len = CNT_W'(1);
        else if (32'(wcount_reg) > 32'(WINDOW_MAX))
            len = CNT_W'(WINDOW_MAX);
        else
            len = CNT_W'(wcount_reg);
    end

    // Saturating idle count for a tick
    assign idle_next = (idle_reg == '1) ? idle_reg : idle_reg + TMO_W'(1);

    assign step_last = (step_reg == IDX_W'(WINDOW_MAX - 1));

    // Tracker compare against the beat leaving the last cell
    assign better = pvld_w[WINDOW_MAX-1] &&
                    ((cnt_w[WINDOW_MAX-1] > best_cnt_reg) ||
                     ((cnt_w[WINDOW_MAX-1] == best_cnt_reg) &&
                      (prb_w[WINDOW_MAX-1] < best_val_reg)));

    // Cell commands
    always_comb
    begin
        ctrl        = '0;
        ctrl.push   = in_acc && !is_tick;
        ctrl.clear  = in_acc && is_tick && (|vld_w) && (idle_next > timeout_reg);
        ctrl.load   = (state_reg == ST_LOAD);
        ctrl.count  = (state_reg == ST_COUNT);
        ctrl.reload = (state_reg == ST_RELOAD);
        ctrl.drain  = (state_reg == ST_DRAIN);
    end

    // Cell chain; the probe path closes into a ring
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic [VALUE_BITS-1:0] val_in;
        logic                  vld_in;
        logic [VALUE_BITS-1:0] prb_in;
        logic                  pvld_in;
        logic [CNT_W-1:0]      cnt_in;

        if (i == 0)
        begin : g_head
            assign val_in  = VALUE_BITS'(sample_ch.sample_value);
            assign vld_in  = 1'b1;
            assign prb_in  = prb_w[WINDOW_MAX-1];
            assign pvld_in = pvld_w[WINDOW_MAX-1];
            assign cnt_in  = cnt_w[WINDOW_MAX-1];
        end
        else
        begin : g_body
            assign val_in  = val_w[i-1];
            assign vld_in  = vld_w[i-1];
            assign prb_in  = prb_w[i-1];
            assign pvld_in = pvld_w[i-1];
            assign cnt_in  = cnt_w[i-1];
        end

        // Cells at or past the window length drop their entry on a push
        assign keep_w[i] = (CNT_W'(i) < len);

        smf_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .keep   (keep_w[i]),
            .val_i  (val_in),
            .vld_i  (vld_in),
            .prb_i  (prb_in),
            .pvld_i (pvld_in),
            .cnt_i  (cnt_in),
            .val_o  (val_w[i]),
            .vld_o  (vld_w[i]),
            .prb_o  (prb_w[i]),
            .pvld_o (pvld_w[i]),
            .cnt_o  (cnt_w[i])
        );
    end

    // Sequencer, timer, registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wcount_reg   <= WINDOW_COUNT_RST;
            timeout_reg  <= TIMEOUT_TICKS_RST;
            idle_reg     <= '0;
            step_reg     <= '0;
            best_val_reg <= '0;
            best_cnt_reg <= '0;
            ov_reg       <= 1'b0;
            out_val_reg  <= '0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW_COUNT:  wcount_reg  <= cfg_data[WCOUNT_W-1:0];
                    CFG_TIMEOUT_TICKS: timeout_reg <= cfg_data[TMO_W-1:0];
                    default: ;
                endcase
            end

            // DONE owns the valid flag while it is writing a result
            if (ov_reg && result_ch.ready && (state_reg != ST_DONE))
                ov_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (is_tick)
                            idle_reg <= idle_next;
                        else
                        begin
                            idle_reg  <= '0;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD:
                begin
                    step_reg     <= '0;
                    best_val_reg <= '0;
                    best_cnt_reg <= '0;
                    state_reg    <= ST_COUNT;
                end
                ST_COUNT:
                begin
                    step_reg <= step_reg + IDX_W'(1);
                    if (step_last)
                        state_reg <= ST_RELOAD;
                end
                ST_RELOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    if (better)
                    begin
                        best_val_reg <= prb_w[WINDOW_MAX-1];
                        best_cnt_reg <= cnt_w[WINDOW_MAX-1];
                    end
                    step_reg <= step_reg + IDX_W'(1);
                    if (step_last)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        ov_reg      <= 1'b1;
                        out_val_reg <= SAMPLE_W'(best_val_reg);
                        out_cnt_reg <= MCOUNT_W'(best_cnt_reg);
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result_ch.valid      = ov_reg;
    assign result_ch.mode_value = out_val_reg;
    assign result_ch.mode_count = out_cnt_reg;

    // Window valid bits always form a run starting at the newest cell
    a_vld_run: assert property (@(posedge clk) disable iff (!rst_n)
        ((vld_w + WINDOW_MAX'(1)) & vld_w) == '0)
        else $error("window valid bits not contiguous");

    // A pushed sample is always held by the head cell
    a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !is_tick) |=> vld_w[0])
        else $error("pushed sample lost at head cell");

    // A new result only comes out of DONE
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside DONE");

    // Drain always finds at least the newest sample
    a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (best_cnt_reg != '0))
        else $error("mode count zero after drain");

    // A tick never fills an empty window
    a_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && is_tick && (vld_w == '0)) |=> (vld_w == '0))
        else $error("empty window filled by a tick");

endmodule

`default_nettype wire

// ===== design/smf_cell.sv =====
// One window cell: holds a sample, its valid bit, a rotating probe and a
// match count. Depends on smf_pkg.
`default_nettype none

module smf_cell #(
    parameter int VALUE_BITS = 16,
    parameter int CNT_W      = 5
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  smf_pkg::smf_cell_ctrl_t     ctrl,
    input  wire                         keep,
    input  wire  [VALUE_BITS-1:0]       val_i,
    input  wire                         vld_i,
    input  wire  [VALUE_BITS-1:0]       prb_i,
    input  wire                         pvld_i,
    input  wire  [CNT_W-1:0]            cnt_i,
    output logic [VALUE_BITS-1:0]       val_o,
    output logic                        vld_o,
    output logic [VALUE_BITS-1:0]       prb_o,
    output logic                        pvld_o,
    output logic [CNT_W-1:0]            cnt_o
);
    import smf_pkg::*;

    logic [VALUE_BITS-1:0] val_reg;
    logic                  vld_reg;
    logic [VALUE_BITS-1:0] prb_reg;
    logic                  pvld_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  match;

    assign match = vld_reg && pvld_reg && (prb_reg == val_reg);

    // Control bits: window valid and probe valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            pvld_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
                vld_reg <= 1'b0;
            else if (ctrl.push)
                vld_reg <= vld_i && keep;

            if (ctrl.load || ctrl.reload)
                pvld_reg <= vld_reg;
            else if (ctrl.count || ctrl.drain)
                pvld_reg <= pvld_i;
        end
    end

    // Payload: sample, probe, match count
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
            val_reg <= val_i;

        if (ctrl.load || ctrl.reload)
            prb_reg <= val_reg;
        else if (ctrl.count || ctrl.drain)
            prb_reg <= prb_i;

        if (ctrl.load)
            cnt_reg <= '0;
        else if (ctrl.count && match)
            cnt_reg <= cnt_reg + CNT_W'(1);
        else if (ctrl.drain)
            cnt_reg <= cnt_i;
    end

    assign val_o  = val_reg;
    assign vld_o  = vld_reg;
    assign prb_o  = prb_reg;
    assign pvld_o = pvld_reg;
    assign cnt_o  = cnt_reg;

endmodule

`default_nettype wire

// ===== tb/tb_sliding_window_mode_filter.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sliding_window_mode_filter: directed and random beats,
// a behavioral window model that predicts every mode result, and a scoreboard.
// Depends on smf_pkg, smf_if and the sliding_window_mode_filter RTL.

module tb_sliding_window_mode_filter;
    import smf_pkg::*;

    localparam int WIN_DEPTH     = 16;
    // Quiet wait used when settling after the last result is back
    localparam int SETTLE_CYCLES = 2 * (2 * WIN_DEPTH + 4);
    localparam int RUN_LIMIT_NS  = 2_000_000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 6;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [MCOUNT_W-1:0] count;
    } mode_beat_t;

    typedef enum int {RX_STEADY, RX_RANDOM, RX_BURSTY} rx_pace_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    smf_in_if  sample_ch ();
    smf_out_if result_ch ();

    sliding_window_mode_filter #(
        .WINDOW_MAX (WIN_DEPTH),
        .VALUE_BITS (SAMPLE_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Window model state, oldest sample at the front
    logic [SAMPLE_W-1:0] win_q[$];
    logic [WCOUNT_W-1:0] win_len_reg;
    logic [TMO_W-1:0]    tmo_reg;
    logic [7:0]          idle_count;

    mode_beat_t          pending_modes[$];
    int unsigned         fault_count;

    // Sender pacing
    int unsigned         burst_left;
    bit                  sender_gapless;

    // Receiver pacing
    rx_pace_t            ready_mode = RX_STEADY;
    int unsigned         ready_left = 0;
    int unsigned         stall_run  = 0;

    function automatic logic [SAMPLE_W-1:0] rand_value();
        return SAMPLE_W'($urandom);
    endfunction

    function automatic void report_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function automatic void window_model_reset();
        win_q.delete();
        win_len_reg = WINDOW_COUNT_RST;
        tmo_reg     = TIMEOUT_TICKS_RST;
        idle_count  = '0;
    endfunction

    function automatic void window_model_config(input logic [CFG_IDX_W-1:0] idx,
                                                input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_WINDOW_COUNT)
            win_len_reg = data[WCOUNT_W-1:0];
        else if (idx == CFG_TIMEOUT_TICKS)
            tmo_reg = data[TMO_W-1:0];
    endfunction

    // Apply one accepted beat to the model; a sample yields the window mode
    function automatic bit window_vote_step(input logic [KIND_W-1:0] k,
                                            input logic [SAMPLE_W-1:0] v,
                                            output mode_beat_t mode);
        int unsigned keep;
        int unsigned hits;
        mode = '0;
        if (k == KIND_TICK) begin
            // saturating increment comes before the timeout compare
            if (idle_count != 8'hFF)
                idle_count++;
            if (win_q.size() > 0 && idle_count > tmo_reg)
                win_q.delete();
            return 1'b0;
        end
        idle_count = '0;
        if (win_q.size() >= WIN_DEPTH)
            win_q.delete(0);
        win_q = {win_q, v};
        // zero length acts as one, beyond the depth acts as the depth
        if (win_len_reg == 0)
            keep = 1;
        else if (win_len_reg > WIN_DEPTH)
            keep = WIN_DEPTH;
        else
            keep = win_len_reg;
        while (win_q.size() > keep)
            win_q.delete(0);
        // most frequent value, smallest wins a tie
        for (int i = 0; i < win_q.size(); i++) begin
            hits = 0;
            for (int j = 0; j < win_q.size(); j++)
                if (win_q[j] == win_q[i])
                    hits++;
            if (hits > mode.count || (hits == mode.count && win_q[i] < mode.value)) begin
                mode.count = hits[MCOUNT_W-1:0];
                mode.value = win_q[i];
            end
        end
        return 1'b1;
    endfunction

    // Scoreboard: each result beat against the oldest prediction
    always @(posedge clk) begin
        mode_beat_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (pending_modes.size() == 0) begin
                report_fault($sformatf("unexpected result value=%h count=%0d",
                                       result_ch.mode_value, result_ch.mode_count));
            end
            else begin
                want = pending_modes[0];
                pending_modes.delete(0);
                if (result_ch.mode_value !== want.value)
                    report_fault($sformatf("mode_value expected %h got %h",
                                           want.value, result_ch.mode_value));
                if (result_ch.mode_count !== want.count)
                    report_fault($sformatf("mode_count expected %0d got %0d (value %h)",
                                           want.count, result_ch.mode_count, want.value));
            end
        end
    end

    // Receiver ready: steady, random or long on/off runs, switching now and then
    always @(posedge clk) begin
        if (ready_left == 0) begin
            ready_mode = rx_pace_t'($urandom_range(0, 2));
            ready_left = $urandom_range(20, 200);
        end
        else
            ready_left--;
        case (ready_mode)
            RX_STEADY: result_ch.ready <= 1'b1;
            RX_RANDOM: result_ch.ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (stall_run == 0) begin
                    stall_run = $urandom_range(1, 30);
                    result_ch.ready <= ~result_ch.ready;
                end
                else
                    stall_run--;
            end
        endcase
    end

    // Send one beat in bursts with random gaps; model it at acceptance
    task automatic send_beat(input logic [KIND_W-1:0] k, input logic [SAMPLE_W-1:0] v);
        mode_beat_t mode;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (!sender_gapless) begin
                sample_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
        burst_left--;
        sample_ch.valid        <= 1'b1;
        sample_ch.kind         <= k;
        sample_ch.sample_value <= v;
        do @(posedge clk); while (sample_ch.ready !== 1'b1);
        if (window_vote_step(k, v, mode))
            pending_modes = {pending_modes, mode};
    endtask

    // Hold off the sender until every result is back and the block is quiet
    task automatic pause_until_drained();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_modes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        pause_until_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        window_model_config(idx, data);
        @(posedge clk);
    endtask

    // Reset defaults: window of five, timeout of ten ticks, ties and extremes
    task automatic test_reset_defaults();
        send_beat(KIND_SAMPLE, 16'h0000);
        send_beat(KIND_SAMPLE, 16'hFFFF);
        send_beat(KIND_SAMPLE, 16'hFFFF);
        send_beat(KIND_SAMPLE, 16'h0000);
        send_beat(KIND_SAMPLE, 16'hA5A5);
        send_beat(KIND_SAMPLE, 16'h5A5A);
        // exactly at the timeout: window kept
        repeat (10) send_beat(KIND_TICK, rand_value());
        send_beat(KIND_SAMPLE, 16'hFFFF);
        // one past the timeout: window cleared
        repeat (11) send_beat(KIND_TICK, rand_value());
        send_beat(KIND_SAMPLE, 16'h1234);
    endtask

    // Window length zero, oversized, full depth, then shrunk by a write
    task automatic test_window_limits();
        write_reg(CFG_WINDOW_COUNT, 8'hE0);
        send_beat(KIND_SAMPLE, 16'h8001);
        send_beat(KIND_SAMPLE, 16'h0001);
        send_beat(KIND_SAMPLE, 16'h8001);
        write_reg(CFG_WINDOW_COUNT, 8'h1F);
        repeat (WIN_DEPTH + 1) send_beat(KIND_SAMPLE, 16'hC3C3);
        write_reg(CFG_WINDOW_COUNT, 8'h02);
        send_beat(KIND_SAMPLE, 16'h3C3C);
    endtask

    // Timeout of zero: the first tick after a sample clears the window
    task automatic test_zero_timeout();
        write_reg(CFG_TIMEOUT_TICKS, 8'h00);
        send_beat(KIND_SAMPLE, 16'h7777);
        send_beat(KIND_TICK, rand_value());
        send_beat(KIND_SAMPLE, 16'h7777);
        send_beat(KIND_SAMPLE, 16'h7777);
    endtask

    // Writes to indexes without a register must change nothing
    task automatic test_unknown_index();
        write_reg(CFG_SPARE_2, 8'hFF);
        write_reg(CFG_SPARE_3, 8'h00);
        send_beat(KIND_SAMPLE, 16'h0F0F);
        send_beat(KIND_SAMPLE, 16'h0F0F);
    endtask

    // Idle counter saturates at 255: never exceeds 255, does exceed 254
    task automatic test_idle_saturation();
        write_reg(CFG_WINDOW_COUNT, 8'h05);
        write_reg(CFG_TIMEOUT_TICKS, 8'hFF);
        send_beat(KIND_SAMPLE, 16'hBEEF);
        repeat (260) send_beat(KIND_TICK, rand_value());
        send_beat(KIND_SAMPLE, 16'hBEEF);
        write_reg(CFG_TIMEOUT_TICKS, 8'hFE);
        repeat (255) send_beat(KIND_TICK, rand_value());
        send_beat(KIND_SAMPLE, 16'hBEEF);
    endtask

    // Random phases: small symbol sets for repeats and ties, tick runs near the timeout
    task automatic test_random_traffic(input int unsigned phase_items);
        logic [SAMPLE_W-1:0]   alphabet[$];
        logic [CFG_DATA_W-1:0] wc;
        logic [CFG_DATA_W-1:0] tmo;
        int unsigned           sent;
        int unsigned           run;
        bit                    paused;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:
                begin
                    wc  = 8'd1;
                    tmo = 8'd1;
                end
                1:
                begin
                    wc  = 8'd16;
                    tmo = 8'd255;
                end
                2:
                begin
                    wc  = 8'd3;
                    tmo = 8'd0;
                end
                default:
                begin
                    wc      = CFG_DATA_W'($urandom);
                    wc[4:0] = WCOUNT_W'($urandom_range(0, 20));
                    if ($urandom_range(0, 3) == 0)
                        tmo = CFG_DATA_W'($urandom);
                    else
                        tmo = CFG_DATA_W'($urandom_range(0, 12));
                end
            endcase
            write_reg(CFG_WINDOW_COUNT, wc);
            write_reg(CFG_TIMEOUT_TICKS, tmo);
            sender_gapless = (phase == 1);

            alphabet.delete();
            repeat ($urandom_range(1, 5)) alphabet = {alphabet, rand_value()};
            if ($urandom_range(0, 1))
                alphabet[0] = '0;
            if ($urandom_range(0, 1))
                alphabet[alphabet.size() - 1] = '1;

            sent   = 0;
            paused = 1'b0;
            while (sent < phase_items) begin
                if ($urandom_range(0, 99) < 15) begin
                    if ($urandom_range(0, 1) && tmo <= 40)
                        run = $urandom_range(tmo, tmo + 2);
                    else
                        run = $urandom_range(1, 4);
                    if (run == 0)
                        run = 1;
                    repeat (run) send_beat(KIND_TICK, rand_value());
                    sent += run;
                end
                else begin
                    if ($urandom_range(0, 9) < 7)
                        send_beat(KIND_SAMPLE, alphabet[$urandom_range(0, alphabet.size() - 1)]);
                    else
                        send_beat(KIND_SAMPLE, rand_value());
                    sent++;
                end
                // mid-phase hold-off until the block has caught up
                if (phase == 3 && !paused && sent >= phase_items / 2) begin
                    pause_until_drained();
                    paused = 1'b1;
                end
            end
        end
        sender_gapless = 1'b0;
    endtask

    initial begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_WINDOW_COUNT;
        cfg_data               = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.kind         = KIND_SAMPLE;
        sample_ch.sample_value = '0;
        result_ch.ready        = 1'b0;
        fault_count            = 0;
        burst_left             = 0;
        sender_gapless         = 1'b0;
        window_model_reset();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_window_limits();
        test_zero_timeout();
        test_unknown_index();
        test_idle_saturation();
        test_random_traffic(35);

        pause_until_drained();
        if (fault_count == 0 && pending_modes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/smf_pkg.sv
design/smf_if.sv
design/smf_cell.sv
design/sliding_window_mode_filter.sv
tb/tb_sliding_window_mode_filter.sv
